>>> rtl/tbpc_pkg.sv
// Shared types, codes and the control store of the blind position controller.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package tbpc_pkg;

   localparam int TIME_W    = 20;
   localparam int DVD_W     = 27;
   localparam int CNT_W     = $clog2(DVD_W + 1);
   localparam int PCT_W     = 7;
   localparam int TGT_W     = 8;
   localparam int CMD_W     = 2;
   localparam int MOT_W     = 2;
   localparam int EV_W      = 2;
   localparam int TICK_W    = 4;
   localparam int CFG_IDX_W = 3;
   localparam int STEP_W    = 3;
   localparam int COND_W    = 2;
   localparam int REQ_W     = 16;
   localparam int RSP_W     = 24;

   localparam int STEP_TICKS_DEF = 10;

   // floor(x / 100) as (x * PCT_RECIP) >> PCT_SHIFT, exact for x below 2^30
   localparam int PCT_SHIFT = 33;

   localparam logic [TIME_W-1:0] OPEN_TIME_RST  = 20'd30000;
   localparam logic [TIME_W-1:0] CLOSE_TIME_RST = 20'd30000;
   localparam logic [DVD_W-1:0]  PCT_RECIP      = 27'd85899346;
   localparam logic [DVD_W-1:0]  PCT_SCALE      = 27'd100;
   localparam logic [PCT_W-1:0]  PCT_FULL       = 7'd100;
   localparam logic [TGT_W-1:0]  TGT_MAX        = 8'd100;

   localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_STOP = 2'd2;
   localparam logic [CMD_W-1:0] CMD_SET  = 2'd3;

   localparam logic [MOT_W-1:0] MOT_IDLE  = 2'd0;
   localparam logic [MOT_W-1:0] MOT_OPEN  = 2'd1;
   localparam logic [MOT_W-1:0] MOT_CLOSE = 2'd2;

   localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
   localparam logic [EV_W-1:0] EV_START = 2'd1;
   localparam logic [EV_W-1:0] EV_STOP  = 2'd2;

   localparam logic [CFG_IDX_W-1:0] REG_OPEN_TIME  = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_CLOSE_TIME = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_ENABLED    = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_INVERT     = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_SWAP       = 3'd4;

   localparam logic [COND_W-1:0] COND_NEVER     = 2'd0;
   localparam logic [COND_W-1:0] COND_NO_ACCEPT = 2'd1;
   localparam logic [COND_W-1:0] COND_BUSY      = 2'd2;
   localparam logic [COND_W-1:0] COND_OUT_BUSY  = 2'd3;

   localparam logic [STEP_W-1:0] ST_FETCH  = 3'd0;
   localparam logic [STEP_W-1:0] ST_EVAL   = 3'd1;
   localparam logic [STEP_W-1:0] ST_WAIT1  = 3'd2;
   localparam logic [STEP_W-1:0] ST_APPLY  = 3'd3;
   localparam logic [STEP_W-1:0] ST_START2 = 3'd4;
   localparam logic [STEP_W-1:0] ST_WAIT2  = 3'd5;
   localparam logic [STEP_W-1:0] ST_DECIDE = 3'd6;

   typedef struct packed {
      logic              accept_en;
      logic              tick_eval;
      logic              div1_start;
      logic              apply;
      logic              div2_start;
      logic              decide;
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] target;
      logic              last;
   } ctrl_type;

   typedef struct packed {
      logic accept;
      logic div_busy;
      logic out_busy;
   } cond_type;

   function automatic ctrl_type ucode_rom(input logic [STEP_W-1:0] step);
      ctrl_type w;
      w = '0;
      case (step)
         ST_FETCH: begin
            w.accept_en = 1'b1;
            w.cond      = COND_NO_ACCEPT;
            w.target    = ST_FETCH;
         end
         ST_EVAL: begin
            w.tick_eval  = 1'b1;
            w.div1_start = 1'b1;
         end
         ST_WAIT1: begin
            w.cond   = COND_BUSY;
            w.target = ST_WAIT1;
         end
         ST_APPLY: begin
            w.apply = 1'b1;
         end
         ST_START2: begin
            w.div2_start = 1'b1;
         end
         ST_WAIT2: begin
            w.cond   = COND_BUSY;
            w.target = ST_WAIT2;
         end
         ST_DECIDE: begin
            w.decide = 1'b1;
            w.cond   = COND_OUT_BUSY;
            w.target = ST_DECIDE;
            w.last   = 1'b1;
         end
         default: begin
            w.last = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

>>> rtl/tbpc_div.sv
// Shared serial divider: restoring division, one quotient bit per cycle.
// Depends on tbpc_pkg for the dividend and divisor widths.
`default_nettype none
module tbpc_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [tbpc_pkg::DVD_W-1:0]  dividend,
   input  wire logic [tbpc_pkg::TIME_W-1:0] divisor,
   output logic                            busy,
   output logic [tbpc_pkg::DVD_W-1:0]       quotient
);
   import tbpc_pkg::*;

   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic [DVD_W-1:0]  quo_ff;
   logic [DVD_W-1:0]  quo_in;
   logic [TIME_W-1:0] rem_ff;
   logic [TIME_W-1:0] rem_in;
   logic [TIME_W-1:0] dsr_ff;
   logic [TIME_W:0]   trial;
   logic [TIME_W:0]   diff;
   logic              ge;

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;
   assign trial    = {rem_ff, quo_ff[DVD_W-1]};
   assign diff     = trial - {1'b0, dsr_ff};
   assign ge       = (trial >= {1'b0, dsr_ff});

   always_comb begin
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (start) begin
         cnt_in = CNT_W'(DVD_W);
         quo_in = dividend;
         rem_in = '0;
      end else if (busy) begin
         cnt_in = cnt_ff - 1'b1;
         quo_in = {quo_ff[DVD_W-2:0], ge};
         rem_in = ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

   assert property (@(posedge clock) disable iff (reset) busy |-> (rem_ff < dsr_ff))
      else $error("divider remainder not below divisor");
   assert property (@(posedge clock) disable iff (reset) busy |-> (dsr_ff != '0))
      else $error("divider running on a zero divisor");
   assert property (@(posedge clock) disable iff (reset) start |=> (cnt_ff == CNT_W'(DVD_W)))
      else $error("divider did not load its count");

endmodule
`default_nettype wire

>>> rtl/tbpc_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on tbpc_pkg for the control word, the condition group and the program.
`default_nettype none
module tbpc_seq (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire tbpc_pkg::cond_type         cond,
   output tbpc_pkg::ctrl_type              ctrl,
   output logic [tbpc_pkg::STEP_W-1:0]     step
);
   import tbpc_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              take;

   assign ctrl = ucode_rom(step_ff);
   assign step = step_ff;

   always_comb begin
      case (ctrl.cond)
         COND_NEVER:     take = 1'b0;
         COND_NO_ACCEPT: take = !cond.accept;
         COND_BUSY:      take = cond.div_busy;
         COND_OUT_BUSY:  take = cond.out_busy;
         default:        take = 1'b0;
      endcase
      if (take) begin
         step_in = ctrl.target;
      end else if (ctrl.last) begin
         step_in = ST_FETCH;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_FETCH;
      end else begin
         step_ff <= step_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
                    (ctrl.decide && cond.out_busy) |=> (step_ff == ST_DECIDE))
      else $error("result step left while the output register was full");
   assert property (@(posedge clock) disable iff (reset)
                    (ctrl.accept_en && !cond.accept) |=> (step_ff == ST_FETCH))
      else $error("sequencer left fetch without a transfer");
   assert property (@(posedge clock) disable iff (reset)
                    $onehot0({ctrl.accept_en, ctrl.tick_eval, ctrl.apply, ctrl.decide}))
      else $error("control word drives more than one datapath phase");

endmodule
`default_nettype wire

>>> rtl/timed_blind_position_controller.sv
// Top level of the timed blind position controller: datapath, config registers,
// result register. Depends on tbpc_pkg, tbpc_seq and tbpc_div.
//
//  channel  ports          payload (lowest bit first)
//  req      req_t*         cmd[1:0], target_pos[9:2]
//  rsp      rsp_t*         open, close, motion, position, event kind/pos/dir
//  csr      csr_*          write-only, index 0..4, 20-bit data
//
// An item is taken only in the fetch step, so the next transfer waits until the
// last one is through: two 27-step divisions on the shared serial divider
// (run-time scaling, then the percent estimate), then the result step.
// Reset is synchronous; no clearing pass. A waiting result holds in the
// output register while the next item is taken; the result step stalls only
// when that register is still full.
`default_nettype none
module timed_blind_position_controller #(
   parameter int STEP_TICKS = tbpc_pkg::STEP_TICKS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // cmd[1:0], target_pos[9:2], zero fill
   input  wire logic [tbpc_pkg::REQ_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // open_drive[0], close_drive[1], motion[3:2], position_pct[10:4],
   // event_kind[12:11], event_pos[19:13], event_dir[21:20], zero fill
   output logic [tbpc_pkg::RSP_W-1:0]          rsp_tdata,
   input  wire logic                          csr_wen,
   input  wire logic [tbpc_pkg::CFG_IDX_W-1:0] csr_index,
   input  wire logic [tbpc_pkg::TIME_W-1:0]    csr_wdata
);
   import tbpc_pkg::*;

   ctrl_type          ctrl;
   cond_type          cond;
   logic [STEP_W-1:0] step;

   logic [TIME_W-1:0] open_ff, open_in, close_ff, close_in;
   logic              enabled_ff, enabled_in, invert_ff, invert_in, swap_ff, swap_in;
   logic [TIME_W-1:0] now_ff, now_in, goal_ff, goal_in, t_ff, t_in;
   logic [MOT_W-1:0]  heading_ff, heading_in;
   logic [TICK_W-1:0] tc_ff, tc_in, el_ff, el_in;
   logic              step_due_ff, step_due_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [TGT_W-1:0]  tgt_ff, tgt_in;
   logic [DVD_W-1:0]  pct_prod_ff, pct_prod_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   logic              accept, out_busy, decide_fire, idle, step_hit, tgt_ok;
   logic [TICK_W-1:0] tc_inc;
   logic [TIME_W-1:0] close_div;
   logic              div_start, div_busy;
   logic [DVD_W-1:0]  dividend, quotient;
   logic [TIME_W-1:0] divisor;
   logic [2*DVD_W-1:0] pct_wide;
   logic [TIME_W-1:0] pct_time;
   logic [PCT_W-1:0]  pos;
   logic [TIME_W:0]   close_sum;
   logic [DVD_W-1:0]  open_cur, open_rem;
   logic              open_under;
   logic              do_halt, do_start, on_open, on_close, drive_a, drive_b;
   logic [MOT_W-1:0]  head_new;
   logic [EV_W-1:0]   ev_kind;
   logic [PCT_W-1:0]  ev_pos;
   logic [MOT_W-1:0]  ev_dir;

   assign out_busy      = rsp_valid_ff && !rsp_tready;
   assign req_tready    = ctrl.accept_en && !reset;
   assign accept        = req_tvalid && req_tready;
   assign decide_fire   = ctrl.decide && !out_busy;
   assign cond.accept   = accept;
   assign cond.div_busy = div_busy;
   assign cond.out_busy = out_busy;

   tbpc_seq u_seq (
      .clock (clock),
      .reset (reset),
      .cond  (cond),
      .ctrl  (ctrl),
      .step  (step)
   );

   assign idle      = !enabled_ff || (now_ff == goal_ff);
   assign tc_inc    = tc_ff + 1'b1;
   assign step_hit  = (tc_inc >= TICK_W'(STEP_TICKS));
   assign close_div = (close_ff == '0) ? TIME_W'(1) : close_ff;
   assign tgt_ok    = (tgt_ff <= TGT_MAX);
   assign div_start = ctrl.div1_start || ctrl.div2_start;

   always_comb begin
      if (ctrl.div2_start) begin
         dividend = DVD_W'(now_ff) * PCT_SCALE;
         divisor  = close_div;
      end else begin
         dividend = DVD_W'(open_ff) * DVD_W'(tc_inc);
         divisor  = close_div;
      end
   end

   tbpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign pct_wide   = (2*DVD_W)'(pct_prod_ff) * (2*DVD_W)'(PCT_RECIP);
   assign pct_time   = pct_wide[PCT_SHIFT+TIME_W-1:PCT_SHIFT];
   assign pos        = (quotient > DVD_W'(PCT_FULL)) ? PCT_FULL : quotient[PCT_W-1:0];
   assign close_sum  = {1'b0, now_ff} + (TIME_W + 1)'(el_ff);
   assign open_cur   = DVD_W'(now_ff);
   assign open_rem   = open_cur - quotient;
   assign open_under = (quotient > open_cur) || (open_rem < DVD_W'(goal_ff));

   always_comb begin
      do_halt  = 1'b0;
      do_start = 1'b0;
      case (cmd_ff)
         CMD_TICK: do_halt = step_due_ff && (now_ff == goal_ff);
         CMD_MOVE: begin
            if (tgt_ok && enabled_ff) begin
               if (!idle) begin
                  do_halt = 1'b1;
               end else if ((tgt_ff == {1'b0, pos}) || (t_ff == now_ff)) begin
                  do_halt = 1'b1;
               end else begin
                  do_start = 1'b1;
               end
            end
         end
         CMD_STOP: do_halt = 1'b1;
         default:  do_halt = 1'b0;
      endcase
      if (do_halt) begin
         head_new = MOT_IDLE;
      end else if (do_start) begin
         head_new = (t_ff > now_ff) ? MOT_CLOSE : MOT_OPEN;
      end else begin
         head_new = heading_ff;
      end
      if (do_halt) begin
         ev_kind = EV_STOP;
         ev_pos  = pos;
         ev_dir  = heading_ff;
      end else if (do_start) begin
         ev_kind = EV_START;
         ev_pos  = pos;
         ev_dir  = head_new;
      end else begin
         ev_kind = EV_NONE;
         ev_pos  = '0;
         ev_dir  = MOT_IDLE;
      end
      on_open  = (head_new == MOT_OPEN);
      on_close = (head_new == MOT_CLOSE);
      drive_a  = (swap_ff ? on_close : on_open) ^ invert_ff;
      drive_b  = (swap_ff ? on_open : on_close) ^ invert_ff;
   end

   always_comb begin
      open_in      = open_ff;
      close_in     = close_ff;
      enabled_in   = enabled_ff;
      invert_in    = invert_ff;
      swap_in      = swap_ff;
      now_in       = now_ff;
      goal_in      = goal_ff;
      t_in         = t_ff;
      heading_in   = heading_ff;
      tc_in        = tc_ff;
      el_in        = el_ff;
      step_due_in  = step_due_ff;
      cmd_in       = cmd_ff;
      tgt_in       = tgt_ff;
      pct_prod_in  = pct_prod_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (accept) begin
         cmd_in      = req_tdata[CMD_W-1:0];
         tgt_in      = req_tdata[CMD_W+TGT_W-1:CMD_W];
         step_due_in = 1'b0;
      end

      if (ctrl.tick_eval) begin
         pct_prod_in = DVD_W'(close_ff) * DVD_W'(tgt_ff[PCT_W-1:0]);
      end

      if (ctrl.tick_eval && (cmd_ff == CMD_TICK) && !idle) begin
         if (step_hit) begin
            tc_in       = '0;
            el_in       = tc_inc;
            step_due_in = 1'b1;
         end else begin
            tc_in = tc_inc;
         end
      end

      if (ctrl.apply) begin
         t_in = pct_time;
         if ((cmd_ff == CMD_TICK) && step_due_ff) begin
            if (heading_ff == MOT_CLOSE) begin
               now_in = (close_sum > {1'b0, goal_ff}) ? goal_ff : close_sum[TIME_W-1:0];
            end else begin
               now_in = open_under ? goal_ff : open_rem[TIME_W-1:0];
            end
         end else if ((cmd_ff == CMD_SET) && tgt_ok) begin
            now_in     = pct_time;
            goal_in    = pct_time;
            heading_in = MOT_IDLE;
            tc_in      = '0;
         end
      end

      if (decide_fire) begin
         heading_in = head_new;
         if (do_halt) begin
            goal_in = now_ff;
            tc_in   = '0;
         end else if (do_start) begin
            goal_in = t_ff;
            tc_in   = '0;
         end
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, ev_dir, ev_pos, ev_kind, pos, head_new, drive_b, drive_a};
      end else if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wen) begin
         case (csr_index)
            REG_OPEN_TIME:  open_in = csr_wdata;
            REG_CLOSE_TIME: close_in = csr_wdata;
            REG_ENABLED: begin
               enabled_in = csr_wdata[0];
               if (!csr_wdata[0]) begin
                  goal_in    = now_ff;
                  tc_in      = '0;
                  heading_in = MOT_IDLE;
               end
            end
            REG_INVERT:     invert_in = csr_wdata[0];
            REG_SWAP:       swap_in = csr_wdata[0];
            default:        open_in = open_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= OPEN_TIME_RST;
         close_ff     <= CLOSE_TIME_RST;
         enabled_ff   <= 1'b1;
         invert_ff    <= 1'b0;
         swap_ff      <= 1'b0;
         now_ff       <= '0;
         goal_ff      <= '0;
         heading_ff   <= MOT_IDLE;
         tc_ff        <= '0;
         step_due_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         open_ff      <= open_in;
         close_ff     <= close_in;
         enabled_ff   <= enabled_in;
         invert_ff    <= invert_in;
         swap_ff      <= swap_in;
         now_ff       <= now_in;
         goal_ff      <= goal_in;
         heading_ff   <= heading_in;
         tc_ff        <= tc_in;
         step_due_ff  <= step_due_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      tgt_ff      <= tgt_in;
      el_ff       <= el_in;
      t_ff        <= t_in;
      pct_prod_ff <= pct_prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
                    ((step == ST_FETCH) && (heading_ff != MOT_IDLE))
                    |-> (enabled_ff && (now_ff != goal_ff)))
      else $error("motor running with no travel left");
   assert property (@(posedge clock) disable iff (reset) tc_ff < TICK_W'(STEP_TICKS))
      else $error("tick counter passed the step length");
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid_ff && (rsp_data_ff[12:11] == EV_START))
                    |-> (rsp_data_ff[21:20] != MOT_IDLE))
      else $error("start event reported without a direction");
   assert property (@(posedge clock) disable iff (reset) accept |=> (step == ST_EVAL))
      else $error("transfer not followed by evaluation");

endmodule
`default_nettype wire
